/* sv/vcri_pkg.sv */
// shared types, codes and constants of the video chip register interface
// no dependencies; imported by every module of the block
package vcri_pkg;

  localparam int SpriteMemBytes = 256;
  localparam int PatternBytes   = 8192;
  localparam int SprAw          = $clog2(SpriteMemBytes);
  localparam int PatAw          = $clog2(PatternBytes);
  localparam int PalAw          = 5;

  localparam int DefNametableBytes = 2048;
  localparam int DefDotsPerLine    = 341;
  localparam int DefLinesPerFrame  = 262;
  localparam int DefVblankLine     = 241;

  localparam logic [1:0] OpWrite   = 2'd0;
  localparam logic [1:0] OpRead    = 2'd1;
  localparam logic [1:0] OpTick    = 2'd2;
  localparam logic [1:0] OpPreload = 2'd3;

  localparam logic [2:0] RegCtrl    = 3'd0;
  localparam logic [2:0] RegMask    = 3'd1;
  localparam logic [2:0] RegStatus  = 3'd2;
  localparam logic [2:0] RegSprAddr = 3'd3;
  localparam logic [2:0] RegSprData = 3'd4;
  localparam logic [2:0] RegScroll  = 3'd5;
  localparam logic [2:0] RegVidAddr = 3'd6;
  localparam logic [2:0] RegVidData = 3'd7;

  localparam logic CfgMirroring = 1'b0;
  localparam logic CfgPatWrite  = 1'b1;

  typedef struct packed {
    logic mirroring_mode;
    logic pattern_writable;
  } vcri_cfg_t;

  typedef struct packed {
    logic             pat_we;
    logic             nt_we;
    logic             pal_we;
    logic             spr_we;
    logic [7:0]       wdata;
    logic [PatAw-1:0] pat_addr;
    logic [PalAw-1:0] pal_addr;
    logic [SprAw-1:0] spr_addr;
  } vcri_mem_ctl_t;

  typedef struct packed {
    logic [7:0] pat;
    logic [7:0] nt;
    logic [7:0] pal;
    logic [7:0] spr;
  } vcri_mem_rd_t;

endpackage

/* sv/video_chip_register_interface_top.sv */
// top level of the video chip register interface: config port, core, memories
// depends on vcri_pkg, vcri_cfg_regs, vcri_mem, vcri_core
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid_i/in_stall_o | op, reg_index, data, pattern_address, tick_cycles
//  out     | from block| out_valid_o/out_stall_i | read_data, nmi_pulse, vblank_started
//  cfg     | to block  | psel/penable/pwrite  | paddr, pwdata, prdata
//
// a beat is accepted only while idle and the output is not stalled; the memories
// are read in that cycle and the result is written back and registered in the next one
// the result sits in an output register; the next beat is taken while it drains
// reset clears the control registers and the sprite valid bits at once, no clearing pass
module video_chip_register_interface_top import vcri_pkg::*; #(
  parameter int NametableBytes = DefNametableBytes,
  parameter int DotsPerLine    = DefDotsPerLine,
  parameter int LinesPerFrame  = DefLinesPerFrame,
  parameter int VblankLine     = DefVblankLine
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  reg_index_i,
  input  logic [7:0]  data_i,
  input  logic [12:0] pattern_address_i,
  input  logic [7:0]  tick_cycles_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        nmi_pulse_o,
  output logic        vblank_started_o
);

  localparam int NtAw = $clog2(NametableBytes);

  vcri_cfg_t       cfg;
  vcri_mem_ctl_t   mem_ctl;
  vcri_mem_rd_t    mem_rd;
  logic [NtAw-1:0] nt_addr;

  vcri_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  vcri_core #(
    .NametableBytes (NametableBytes),
    .DotsPerLine    (DotsPerLine),
    .LinesPerFrame  (LinesPerFrame),
    .VblankLine     (VblankLine),
    .NtAw           (NtAw)
  ) u_core (
    .clk_i, .rst_ni,
    .cfg_i (cfg),
    .in_valid_i, .in_stall_o, .op_i, .reg_index_i, .data_i, .pattern_address_i,
    .tick_cycles_i, .out_valid_o, .out_stall_i, .read_data_o, .nmi_pulse_o,
    .vblank_started_o,
    .mem_ctl_o (mem_ctl),
    .nt_addr_o (nt_addr),
    .mem_rd_i  (mem_rd)
  );

  vcri_mem #(
    .NametableBytes (NametableBytes),
    .NtAw           (NtAw)
  ) u_mem (
    .clk_i, .rst_ni,
    .ctl_i     (mem_ctl),
    .nt_addr_i (nt_addr),
    .rd_o      (mem_rd)
  );

endmodule

/* sv/vcri_cfg_regs.sv */
// apb-style configuration registers: mirroring mode and pattern write enable
// depends on vcri_pkg
module vcri_cfg_regs import vcri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output vcri_cfg_t   cfg_o
);

  vcri_cfg_t cfg_q, cfg_d;
  logic      wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        CfgMirroring: cfg_d.mirroring_mode   = pwdata[0];
        CfgPatWrite:  cfg_d.pattern_writable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CfgMirroring: prdata = {31'd0, cfg_q.mirroring_mode};
      CfgPatWrite:  prdata = {31'd0, cfg_q.pattern_writable};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/vcri_mem.sv */
// pattern, nametable, palette and sprite memories, registered synchronous read
// depends on vcri_pkg; sprite entries carry valid bits so they read zero after reset
module vcri_mem import vcri_pkg::*; #(
  parameter int NametableBytes = DefNametableBytes,
  parameter int NtAw           = $clog2(NametableBytes)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vcri_mem_ctl_t   ctl_i,
  input  logic [NtAw-1:0] nt_addr_i,
  output vcri_mem_rd_t    rd_o
);

  logic [7:0] pat_mem [PatternBytes];
  logic [7:0] nt_mem  [NametableBytes];
  logic [7:0] pal_mem [2**PalAw];
  logic [7:0] spr_mem [SpriteMemBytes];
  logic [SpriteMemBytes-1:0] spr_valid_q;
  logic       spr_rvalid_q;
  logic [7:0] spr_raw_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_we) begin
      pat_mem[ctl_i.pat_addr] <= ctl_i.wdata;
    end
    if (ctl_i.nt_we) begin
      nt_mem[nt_addr_i] <= ctl_i.wdata;
    end
    if (ctl_i.pal_we) begin
      pal_mem[ctl_i.pal_addr] <= ctl_i.wdata;
    end
    if (ctl_i.spr_we) begin
      spr_mem[ctl_i.spr_addr] <= ctl_i.wdata;
    end
    rd_o.pat  <= pat_mem[ctl_i.pat_addr];
    rd_o.nt   <= nt_mem[nt_addr_i];
    rd_o.pal  <= pal_mem[ctl_i.pal_addr];
    spr_raw_q <= spr_mem[ctl_i.spr_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_valid_q  <= '0;
      spr_rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.spr_we) begin
        spr_valid_q[ctl_i.spr_addr] <= 1'b1;
      end
      spr_rvalid_q <= spr_valid_q[ctl_i.spr_addr];
    end
  end

  assign rd_o.spr = spr_rvalid_q ? spr_raw_q : 8'd0;

endmodule

/* sv/vcri_core.sv */
// register file, item sequencer and dot/line timing of the register interface
// depends on vcri_pkg; drives the memories in vcri_mem
module vcri_core import vcri_pkg::*; #(
  parameter int NametableBytes = DefNametableBytes,
  parameter int DotsPerLine    = DefDotsPerLine,
  parameter int LinesPerFrame  = DefLinesPerFrame,
  parameter int VblankLine     = DefVblankLine,
  parameter int NtAw           = $clog2(NametableBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vcri_cfg_t        cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [2:0]       reg_index_i,
  input  logic [7:0]       data_i,
  input  logic [12:0]      pattern_address_i,
  input  logic [7:0]       tick_cycles_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             nmi_pulse_o,
  output logic             vblank_started_o,
  output vcri_mem_ctl_t    mem_ctl_o,
  output logic [NtAw-1:0]  nt_addr_o,
  input  vcri_mem_rd_t     mem_rd_i
);

  localparam logic [9:0] DotsW  = 10'(DotsPerLine);
  localparam logic [8:0] LinesW = 9'(LinesPerFrame);
  localparam logic [8:0] VblW   = 9'(VblankLine);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e      state_q, state_d;
  logic [1:0]  op_q;
  logic [2:0]  reg_q;
  logic [7:0]  data_q;
  logic [12:0] paddr_q;
  logic [7:0]  cyc_q;

  logic        toggle_q, toggle_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [4:0]  mask_q, mask_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  spr_addr_q, spr_addr_d;
  logic [7:0]  spr0_q, spr0_d;
  logic [7:0]  scroll_q [2];
  logic [15:0] va_q, va_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [9:0]  dot_q, dot_d;
  logic [8:0]  line_q, line_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  rd_q, rd_d;
  logic        nmi_q, nmi_d;
  logic        vbl_q, vbl_d;

  logic        accept, exec;
  logic [13:0] vaddr;
  logic        in_pat, in_nt;
  logic        bank;
  logic [10:0] nt_idx;
  logic [4:0]  pal_idx;
  logic [7:0]  pal_val;
  logic [15:0] va_next;
  logic [9:0]  dot_sum;
  logic [8:0]  line_inc;
  logic        scroll_we;

  assign in_stall_o = (state_q == S_EXEC) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign exec       = (state_q == S_EXEC);

  // addresses follow the state, which holds still from accept until the end of exec
  assign vaddr   = va_q[13:0];
  assign in_pat  = (vaddr < 14'h2000);
  assign in_nt   = !in_pat && (vaddr < 14'h3f00);
  assign bank    = cfg_i.mirroring_mode ? vaddr[10] : vaddr[11];
  assign nt_idx  = {bank, vaddr[9:0]};
  assign pal_idx = {vaddr[4] & (vaddr[1:0] != 2'b00), vaddr[3:0]};
  assign pal_val = mask_q[0] ? (mem_rd_i.pal & 8'h30) : mem_rd_i.pal;
  assign va_next = {2'b00, vaddr} + (ctrl_q[2] ? 16'd32 : 16'd1);
  assign dot_sum = dot_q + {2'b00, cyc_q};
  assign line_inc = line_q + 9'd1;

  assign nt_addr_o = NtAw'(nt_idx);

  always_comb begin
    mem_ctl_o          = '0;
    mem_ctl_o.pat_addr = (exec && op_q == OpPreload) ? paddr_q : vaddr[12:0];
    mem_ctl_o.pal_addr = pal_idx;
    mem_ctl_o.spr_addr = spr_addr_q;
    mem_ctl_o.wdata    = data_q;
    if (exec) begin
      unique case (op_q)
        OpWrite: begin
          mem_ctl_o.spr_we = (reg_q == RegSprData);
          if (reg_q == RegVidData) begin
            mem_ctl_o.pat_we = in_pat & cfg_i.pattern_writable;
            mem_ctl_o.nt_we  = in_nt;
            mem_ctl_o.pal_we = !in_pat && !in_nt;
          end
        end
        OpPreload: mem_ctl_o.pat_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    toggle_d   = toggle_q;
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    status_d   = status_q;
    spr_addr_d = spr_addr_q;
    spr0_d     = spr0_q;
    va_d       = va_q;
    rbuf_d     = rbuf_q;
    dot_d      = dot_q;
    line_d     = line_q;
    scroll_we  = 1'b0;
    rd_d       = rd_q;
    nmi_d      = nmi_q;
    vbl_d      = vbl_q;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        rd_d        = 8'd0;
        nmi_d       = 1'b0;
        vbl_d       = 1'b0;
        unique case (op_q)
          OpWrite: begin
            unique case (reg_q)
              RegCtrl: begin
                nmi_d  = !ctrl_q[7] && data_q[7] && status_q[2];
                ctrl_d = data_q;
              end
              RegMask:    mask_d = data_q[4:0];
              RegSprAddr: spr_addr_d = data_q;
              RegSprData: begin
                if (spr_addr_q == 8'd0) begin
                  spr0_d = data_q;
                end
                spr_addr_d = spr_addr_q + 8'd1;
              end
              RegScroll: begin
                scroll_we = 1'b1;
                toggle_d  = ~toggle_q;
              end
              RegVidAddr: begin
                if (!toggle_q) begin
                  va_d = {data_q, va_q[7:0]};
                end else begin
                  va_d = {va_q[15:8], data_q};
                end
                toggle_d = ~toggle_q;
              end
              RegVidData: va_d = va_next;
              default: ;
            endcase
          end
          OpRead: begin
            unique case (reg_q)
              RegStatus: begin
                rd_d        = {status_q, 5'd0};
                status_d[2] = 1'b0;
                toggle_d    = 1'b0;
              end
              RegSprData: rd_d = mem_rd_i.spr;
              RegVidData: begin
                va_d = va_next;
                if (in_pat) begin
                  rd_d   = rbuf_q;
                  rbuf_d = mem_rd_i.pat;
                end else if (in_nt) begin
                  rd_d   = rbuf_q;
                  rbuf_d = mem_rd_i.nt;
                end else begin
                  rd_d   = pal_val;
                  rbuf_d = pal_val;
                end
              end
              default: ;
            endcase
          end
          OpTick: begin
            dot_d = dot_sum;
            if (dot_sum >= DotsW) begin
              if ({1'b0, spr0_q} == line_q && mask_q[4:3] == 2'b11) begin
                status_d[1] = 1'b1;
              end
              dot_d  = dot_sum - DotsW;
              line_d = line_inc;
              if (line_inc == VblW) begin
                status_d[2] = 1'b1;
                vbl_d       = 1'b1;
                nmi_d       = ctrl_q[7];
              end
              // vblank start and nmi still reported when the frame wraps on the same line; status flags are cleared
              if (line_inc >= LinesW) begin
                line_d   = 9'd0;
                status_d = 3'd0;
              end
            end
          end
          OpPreload: ;
          default: ;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      reg_q   <= reg_index_i;
      data_q  <= data_i;
      paddr_q <= pattern_address_i;
      cyc_q   <= tick_cycles_i;
    end
    rd_q  <= rd_d;
    nmi_q <= nmi_d;
    vbl_q <= vbl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      toggle_q    <= 1'b0;
      ctrl_q      <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      spr_addr_q  <= '0;
      spr0_q      <= '0;
      scroll_q[0] <= '0;
      scroll_q[1] <= '0;
      va_q        <= '0;
      rbuf_q      <= '0;
      dot_q       <= '0;
      line_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      toggle_q    <= toggle_d;
      ctrl_q      <= ctrl_d;
      mask_q      <= mask_d;
      status_q    <= status_d;
      spr_addr_q  <= spr_addr_d;
      spr0_q      <= spr0_d;
      if (scroll_we) begin
        scroll_q[toggle_q] <= data_q;
      end
      va_q        <= va_d;
      rbuf_q      <= rbuf_d;
      dot_q       <= dot_d;
      line_q      <= line_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rd_q;
  assign nmi_pulse_o      = nmi_q;
  assign vblank_started_o = vbl_q;

endmodule

/* sv/vcri_checker.sv */
// port-level checks of the video chip register interface, bound to the top level
// depends on vcri_pkg and video_chip_register_interface_top
module vcri_checker import vcri_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] op_i,
  input logic [2:0] reg_index_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       vblank_started_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("beat taken while previous item in flight");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##1 out_valid_o)
    else $error("no result two cycles after accept");

  a_no_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i != OpRead || reg_index_i == RegMask) |=> ##1 read_data_o == 8'd0)
    else $error("nonzero read data for item without readback");

  a_vbl_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i != OpTick |=> ##1 !vblank_started_o)
    else $error("vblank reported for non-tick item");

endmodule

bind video_chip_register_interface_top vcri_checker u_vcri_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .reg_index_i,
  .out_valid_o, .out_stall_i, .read_data_o, .vblank_started_o
);
